// File: sv/framebuffer_line_and_rect_drawer_assert.svh
// Assertion macros for the drawing engine
`ifndef FRAMEBUFFER_LINE_AND_RECT_DRAWER_ASSERT_SVH
`define FRAMEBUFFER_LINE_AND_RECT_DRAWER_ASSERT_SVH
`ifndef SYNTH
`define FB_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define FB_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define FB_ASSERT_IMP(label, clk, rst_n, a, b, msg)
`define FB_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: sv/fbd_pkg.sv
package fbd_pkg;
    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRACTION_BITS = 16;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int ACCW = 12 + FRACTION_BITS + 1;
    localparam int QW = 12 + FRACTION_BITS;

    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef enum logic [2:0] {
        OP_SET   = 3'd0,
        OP_FILL  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_LINE  = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RECT, ST_DIVX, ST_DIVY, ST_LINE, ST_RD0, ST_RD1, ST_OUT
    } state_t;

    typedef struct packed {
        logic          start;
        logic [QW-1:0] dividend;
        logic [11:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;
endpackage

// File: sv/fbd_if.sv
interface fbd_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [11:0] x_first;
    logic [11:0] y_first;
    logic [11:0] x_second;
    logic [11:0] y_second;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic [31:0] color;
    modport source (output valid, operation, x_first, y_first, x_second, y_second,
                    rect_width, rect_height, color, input ready);
    modport sink (input valid, operation, x_first, y_first, x_second, y_second,
                  rect_width, rect_height, color, output ready);
endinterface

interface fbd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic        out_of_area;
    modport source (output valid, pixel_value, out_of_area, input ready);
    modport sink (input valid, pixel_value, out_of_area, output ready);
endinterface

// File: sv/fbd_divider.sv
module fbd_divider
    import fbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CW = $clog2(QW + 1);
    logic [QW-1:0] quo_reg;
    logic [11:0]   rem_reg;
    logic [11:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [12:0]   trial;

    assign trial = {rem_reg, quo_reg[QW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= 12'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[11:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: sv/fbd_frame_ram.sv
module fbd_frame_ram
    import fbd_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: sv/framebuffer_line_and_rect_drawer.sv
// Clipped drawing engine over a 256x256 word framebuffer in one single-port-write,
// registered-read RAM. One command at a time. A clipped set, an empty fill, a
// zero-step line, an out-of-area read and unknown codes go straight to the result;
// set pixel writes its pixel first; read pixel goes through ST_RD0 and ST_RD1;
// fill and clear write one pixel per cycle inside the clipped area; a line runs
// its two serial divisions, then takes one step per cycle, writing each point that
// lies inside the area. A result is held until it is taken. The framebuffer has
// no reset value and must be written before it is read.
// Registers: width_in_use at 0x0, height_in_use at 0x4; both read back.
module framebuffer_line_and_rect_drawer
    import fbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbd_cmd_if.sink     cmd,
    fbd_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "framebuffer_line_and_rect_drawer_assert.svh"

    logic [8:0] width_reg, height_reg;
    logic [8:0] aw, ah;
    assign pready = 1'b1;
    assign aw = (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign ah = (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == REG_WIDTH)
                width_reg <= pwdata[8:0];
            else if (paddr == REG_HEIGHT)
                height_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_WIDTH)
            prdata = {23'd0, width_reg};
        else if (paddr == REG_HEIGHT)
            prdata = {23'd0, height_reg};
    end

    state_t state_reg, state_next;
    logic [12:0] x_reg, x_next, y_reg, y_next;
    logic [12:0] x0_reg, x0_next, xe_reg, xe_next, ye_reg, ye_next;
    logic [31:0] color_reg, color_next;
    logic [ACCW-1:0] px_reg, px_next, py_reg, py_next, ix_reg, ix_next, iy_reg, iy_next;
    logic [11:0] steps_reg, steps_next, cnt_reg, cnt_next;
    logic nx_reg, nx_next, ny_reg, ny_next;
    logic [11:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [31:0] pix_reg, pix_next;
    logic oob_reg, oob_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] rdata;
    logic [12:0] wx, wy;
    logic [16:0] lin;
    div_req_t dreq;
    div_rsp_t drsp;

    assign lin = 17'(wy) * 17'(aw) + 17'(wx);
    assign waddr = lin[AW-1:0];
    assign raddr = lin[AW-1:0];

    fbd_frame_ram u_ram (.clk, .we, .waddr, .wdata(color_reg), .raddr, .rdata);
    fbd_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; x0_reg <= x0_next;
        xe_reg <= xe_next; ye_reg <= ye_next; color_reg <= color_next;
        px_reg <= px_next; py_reg <= py_next; ix_reg <= ix_next; iy_reg <= iy_next;
        steps_reg <= steps_next; cnt_reg <= cnt_next;
        nx_reg <= nx_next; ny_reg <= ny_next; ax_reg <= ax_next; ay_reg <= ay_next;
        pix_reg <= pix_next; oob_reg <= oob_next;
    end

    logic [12:0] dxs, dys, xend, yend;
    logic [ACCW-1:0] qext;

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg; y_next = y_reg; x0_next = x0_reg;
        xe_next = xe_reg; ye_next = ye_reg; color_next = color_reg;
        px_next = px_reg; py_next = py_reg; ix_next = ix_reg; iy_next = iy_reg;
        steps_next = steps_reg; cnt_next = cnt_reg;
        nx_next = nx_reg; ny_next = ny_reg; ax_next = ax_reg; ay_next = ay_reg;
        pix_next = pix_reg; oob_next = oob_reg;
        cmd.ready = 1'b0;
        res.valid = 1'b0;
        we = 1'b0;
        wx = x_reg; wy = y_reg;
        dreq = '0;
        dxs = {1'b0, cmd.x_second} - {1'b0, cmd.x_first};
        dys = {1'b0, cmd.y_second} - {1'b0, cmd.y_first};
        xend = {1'b0, cmd.x_first} + {1'b0, cmd.rect_width};
        yend = {1'b0, cmd.y_first} + {1'b0, cmd.rect_height};
        qext = {1'b0, drsp.quotient};
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    color_next = cmd.color;
                    pix_next = '0;
                    oob_next = 1'b0;
                    x_next = {1'b0, cmd.x_first};
                    y_next = {1'b0, cmd.y_first};
                    x0_next = {1'b0, cmd.x_first};
                    state_next = ST_OUT;
                    case (cmd.operation)
                        OP_SET:
                        begin
                            if (cmd.x_first < 12'(aw) && cmd.y_first < 12'(ah))
                            begin
                                xe_next = {1'b0, cmd.x_first} + 13'd1;
                                ye_next = {1'b0, cmd.y_first} + 13'd1;
                                state_next = ST_RECT;
                            end
                        end
                        OP_FILL:
                        begin
                            xe_next = (xend > 13'(aw)) ? 13'(aw) : xend;
                            ye_next = (yend > 13'(ah)) ? 13'(ah) : yend;
                            if (cmd.x_first < 12'(aw) && cmd.y_first < 12'(ah)
                                && cmd.rect_width != 0 && cmd.rect_height != 0)
                                state_next = ST_RECT;
                        end
                        OP_CLEAR:
                        begin
                            x_next = '0; y_next = '0; x0_next = '0;
                            xe_next = 13'(aw); ye_next = 13'(ah);
                            if (aw != 0 && ah != 0)
                                state_next = ST_RECT;
                        end
                        OP_LINE:
                        begin
                            nx_next = dxs[12];
                            ny_next = dys[12];
                            ax_next = dxs[12] ? 12'(-dxs) : dxs[11:0];
                            ay_next = dys[12] ? 12'(-dys) : dys[11:0];
                            steps_next = (ax_next > ay_next) ? ax_next : ay_next;
                            px_next = ACCW'({cmd.x_first, FRACTION_BITS'(0)});
                            py_next = ACCW'({cmd.y_first, FRACTION_BITS'(0)});
                            if (steps_next != 0)
                            begin
                                dreq.start = 1'b1;
                                dreq.dividend = {ax_next, FRACTION_BITS'(0)};
                                dreq.divisor = steps_next;
                                state_next = ST_DIVX;
                            end
                        end
                        OP_READ:
                        begin
                            if (cmd.x_first < 12'(aw) && cmd.y_first < 12'(ah))
                                state_next = ST_RD0;
                            else
                                oob_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RECT:
            begin
                we = 1'b1;
                if (x_reg + 13'd1 >= xe_reg)
                begin
                    x_next = x0_reg;
                    y_next = y_reg + 13'd1;
                    if (y_reg + 13'd1 >= ye_reg)
                        state_next = ST_OUT;
                end
                else
                    x_next = x_reg + 13'd1;
            end
            ST_DIVX:
            begin
                if (drsp.done)
                begin
                    ix_next = nx_reg ? ACCW'(-qext) : qext;
                    dreq.start = 1'b1;
                    dreq.dividend = {ay_reg, FRACTION_BITS'(0)};
                    dreq.divisor = steps_reg;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (drsp.done)
                begin
                    iy_next = ny_reg ? ACCW'(-qext) : qext;
                    cnt_next = steps_reg;
                    state_next = ST_LINE;
                end
            end
            ST_LINE:
            begin
                wx = {1'b0, px_reg[ACCW-2:FRACTION_BITS]};
                wy = {1'b0, py_reg[ACCW-2:FRACTION_BITS]};
                we = (wx < 13'(aw)) && (wy < 13'(ah));
                px_next = px_reg + ix_reg;
                py_next = py_reg + iy_reg;
                cnt_next = cnt_reg - 12'd1;
                if (cnt_reg == 12'd1)
                    state_next = ST_OUT;
            end
            ST_RD0: state_next = ST_RD1;
            ST_RD1:
            begin
                pix_next = rdata;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                res.valid = 1'b1;
                if (res.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res.pixel_value = pix_reg;
    assign res.out_of_area = oob_reg;

    `FB_ASSERT_IMP(a_no_ready_busy, clk, rst_n, state_reg != ST_IDLE, !cmd.ready,
        "ready while busy")
    `FB_ASSERT_IMP(a_we_in_area, clk, rst_n, we, (wx < 13'(aw)) && (wy < 13'(ah)),
        "write outside area")
    `FB_ASSERT_NEXT(a_out_hold, clk, rst_n, res.valid && !res.ready,
        res.valid && $stable(res.pixel_value), "result dropped")
endmodule

// File: tb/framebuffer_line_and_rect_drawer_test.sv
module framebuffer_line_and_rect_drawer_test;
    import fbd_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 300000;

    typedef struct {
        logic [31:0] pixel_value;
        logic        out_of_area;
    } pixel_result_t;

    class drawer_scoreboard;
        logic [31:0]   frame[MAX_WIDTH*MAX_HEIGHT];
        bit            written[MAX_WIDTH*MAX_HEIGHT];
        int unsigned   width_in_use = 256;
        int unsigned   height_in_use = 256;
        pixel_result_t pending_reads[$];
        int            failures = 0;
        int            checked = 0;

        function int unsigned area_w();
            return width_in_use > MAX_WIDTH ? MAX_WIDTH : width_in_use;
        endfunction

        function int unsigned area_h();
            return height_in_use > MAX_HEIGHT ? MAX_HEIGHT : height_in_use;
        endfunction

        function void plot(int unsigned x, int unsigned y, logic [31:0] c);
            if (x < area_w() && y < area_h()) begin
                frame[y*area_w()+x] = c;
                written[y*area_w()+x] = 1'b1;
            end
        endfunction

        function void fill(int unsigned x0, int unsigned y0, int unsigned w, int unsigned h,
                           logic [31:0] c);
            int unsigned x_end;
            int unsigned y_end;
            x_end = (x0 + w > area_w()) ? area_w() : x0 + w;
            y_end = (y0 + h > area_h()) ? area_h() : y0 + h;
            for (int unsigned y = y0; y < y_end; y++)
                for (int unsigned x = x0; x < x_end; x++)
                    plot(x, y, c);
        endfunction

        function longint step_of(longint d, longint steps);
            longint mag;
            longint q;
            mag = d < 0 ? -d : d;
            q = (mag << FRACTION_BITS) / steps;
            return d < 0 ? -q : q;
        endfunction

        function void line(longint x1, longint y1, longint x2, longint y2, logic [31:0] c);
            longint dx;
            longint dy;
            longint steps;
            longint ix;
            longint iy;
            longint px;
            longint py;
            dx = x2 - x1;
            dy = y2 - y1;
            steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                              : (dy < 0 ? -dy : dy);
            if (steps == 0)
                return;
            ix = step_of(dx, steps);
            iy = step_of(dy, steps);
            px = x1 << FRACTION_BITS;
            py = y1 << FRACTION_BITS;
            for (longint k = 0; k < steps; k++) begin
                if (px >= 0 && py >= 0)
                    plot(32'(px >>> FRACTION_BITS), 32'(py >>> FRACTION_BITS), c);
                px += ix;
                py += iy;
            end
        endfunction

        function void note_command(logic [2:0] op, logic [11:0] xf, logic [11:0] yf,
                                   logic [11:0] xs, logic [11:0] ys, logic [11:0] rw,
                                   logic [11:0] rh, logic [31:0] c);
            pixel_result_t r;
            r.pixel_value = '0;
            r.out_of_area = 1'b0;
            case (op)
                OP_SET:   plot(xf, yf, c);
                OP_FILL:  fill(xf, yf, rw, rh, c);
                OP_CLEAR: fill(0, 0, area_w(), area_h(), c);
                OP_LINE:  line(xf, yf, xs, ys, c);
                OP_READ:
                    if (xf < area_w() && yf < area_h())
                        r.pixel_value = frame[yf*area_w()+xf];
                    else
                        r.out_of_area = 1'b1;
                default: ;
            endcase
            pending_reads.push_back(r);
        endfunction

        function void check_result(logic [31:0] pixel_value, logic out_of_area);
            pixel_result_t e;
            checked++;
            if (pending_reads.size() == 0) begin
                $error("result with nothing expected: pixel_value %h", pixel_value);
                failures++;
                return;
            end
            e = pending_reads.pop_front();
            if (pixel_value !== e.pixel_value) begin
                $error("pixel_value expected %h actual %h", e.pixel_value, pixel_value);
                failures++;
            end
            if (out_of_area !== e.out_of_area) begin
                $error("out_of_area expected %b actual %b", e.out_of_area, out_of_area);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          calm;
    int          idle_cycles;
    int          commands_sent;

    fbd_cmd_if cmd_bus();
    fbd_res_if res_bus();
    drawer_scoreboard sb = new();

    framebuffer_line_and_rect_drawer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus.sink),
        .res     (res_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (res_bus.valid && res_bus.ready)
                sb.check_result(res_bus.pixel_value, res_bus.out_of_area);
            if ((res_bus.valid && res_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
        res_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end

    task automatic send_command(logic [2:0] op, logic [11:0] xf, logic [11:0] yf,
                                logic [11:0] xs, logic [11:0] ys, logic [11:0] rw,
                                logic [11:0] rh, logic [31:0] c);
        if (!calm && $urandom_range(99) < 36) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.x_first <= xf;
        cmd_bus.y_first <= yf;
        cmd_bus.x_second <= xs;
        cmd_bus.y_second <= ys;
        cmd_bus.rect_width <= rw;
        cmd_bus.rect_height <= rh;
        cmd_bus.color <= c;
        do
            @(posedge clk);
        while (!(cmd_bus.valid && cmd_bus.ready));
        sb.note_command(op, xf, yf, xs, ys, rw, rh, c);
        commands_sent++;
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (sb.pending_reads.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [11:0] pick_coord(int unsigned limit);
        if ($urandom_range(9) == 0)
            return 12'($urandom_range(4095));
        return 12'($urandom_range(limit + 3));
    endfunction

    task automatic send_random();
        int unsigned sel;
        int unsigned aw;
        int unsigned ah;
        logic [11:0] xf;
        logic [11:0] yf;
        logic [11:0] xs;
        logic [11:0] ys;
        logic [11:0] rw;
        logic [11:0] rh;
        sel = $urandom_range(99);
        aw = sb.area_w();
        ah = sb.area_h();
        xf = pick_coord(aw);
        yf = pick_coord(ah);
        xs = pick_coord(aw);
        ys = pick_coord(ah);
        rw = 12'($urandom_range(12));
        rh = 12'($urandom_range(12));
        if ($urandom_range(19) == 0) begin
            rw = 12'($urandom_range(4095));
            rh = 12'($urandom_range(4095));
        end
        if (sel < 20)
            send_command(OP_SET, xf, yf, xs, ys, rw, rh, $urandom());
        else if (sel < 40)
            send_command(OP_FILL, xf, yf, xs, ys, rw, rh, $urandom());
        else if (sel < 41 && aw * ah <= 4096)
            send_command(OP_CLEAR, xf, yf, xs, ys, rw, rh, $urandom());
        else if (sel < 66)
            send_command(OP_LINE, xf, yf, xs, ys, rw, rh, $urandom());
        else if (sel < 97) begin
            if (xf < aw && yf < ah && !sb.written[yf*aw+xf])
                xf = 12'(aw + $urandom_range(3));
            send_command(OP_READ, xf, yf, xs, ys, rw, rh, $urandom());
        end
        else
            send_command(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), xf, yf, xs, ys,
                         rw, rh, $urandom());
    endtask

    int unsigned widths[9] = '{256, 1, 511, 0, 33, 256, 5, 100, 256};
    int unsigned heights[9] = '{256, 1, 300, 7, 17, 1, 256, 60, 256};

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        idle_cycles = 0;
        commands_sent = 0;
        cmd_bus.valid = 1'b0;
        cmd_bus.operation = OP_SET;
        cmd_bus.x_first = '0;
        cmd_bus.y_first = '0;
        cmd_bus.x_second = '0;
        cmd_bus.y_second = '0;
        cmd_bus.rect_width = '0;
        cmd_bus.rect_height = '0;
        cmd_bus.color = '0;
        res_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
        send_command(OP_SET, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_command(OP_SET, 255, 255, 0, 0, 0, 0, 32'h1234_5678);
        send_command(OP_SET, 256, 0, 0, 0, 0, 0, 32'hDEAD_BEEF);
        send_command(OP_SET, 4095, 4095, 0, 0, 0, 0, 32'hDEAD_BEEF);
        send_command(OP_FILL, 0, 0, 0, 0, 0, 5, 32'hAAAA_AAAA);
        send_command(OP_FILL, 250, 250, 0, 0, 4095, 4095, 32'h5555_5555);
        send_command(OP_FILL, 3, 4, 0, 0, 2, 3, 32'h0F0F_0F0F);
        send_command(OP_LINE, 7, 7, 7, 7, 0, 0, 32'hCAFE_0001);
        send_command(OP_LINE, 2, 10, 40, 10, 0, 0, 32'hCAFE_0002);
        send_command(OP_LINE, 20, 50, 20, 2, 0, 0, 32'hCAFE_0003);
        send_command(OP_LINE, 90, 90, 10, 10, 0, 0, 32'hCAFE_0004);
        send_command(OP_LINE, 5, 3, 12, 97, 0, 0, 32'hCAFE_0005);
        send_command(OP_LINE, 4095, 4095, 0, 0, 0, 0, 32'hCAFE_0006);
        send_command(OP_LINE, 0, 4095, 4095, 0, 0, 0, 32'hCAFE_0007);
        send_command(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ, 255, 255, 0, 0, 0, 0, 0);
        send_command(OP_READ, 4, 5, 0, 0, 0, 0, 0);
        send_command(OP_READ, 30, 10, 0, 0, 0, 0, 0);
        send_command(OP_READ, 256, 3, 0, 0, 0, 0, 0);
        send_command(OP_READ, 3, 4095, 0, 0, 0, 0, 0);
        send_command(OP_UNUSED_HI, 1, 1, 2, 2, 3, 3, 32'hFFFF_FFFF);
        send_command(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 9; phase++) begin
            if (phase > 0) begin
                drain();
                write_register(REG_WIDTH, widths[phase]);
                write_register(REG_HEIGHT, heights[phase]);
                sb.width_in_use = widths[phase] & 32'h1FF;
                sb.height_in_use = heights[phase] & 32'h1FF;
                send_command(OP_CLEAR, 0, 0, 0, 0, 0, 0, $urandom());
            end
            for (int n = 0; n < 180; n++) begin
                calm = (phase == 4);
                send_random();
            end
        end
        calm = 1'b0;
        drain();

        $display("drove %0d commands through 9 area settings, checked %0d results",
                 commands_sent, sb.checked);
        if (sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/fbd_pkg.sv
sv/fbd_if.sv
sv/fbd_divider.sv
sv/fbd_frame_ram.sv
sv/framebuffer_line_and_rect_drawer.sv
tb/framebuffer_line_and_rect_drawer_test.sv
